// ----- design/mcant_pkg.sv -----
// Shared types and constants for the multi-color ant grid stepper.
// Holds field widths, request modes, result status codes, headings and register indexes.
// No dependencies.
package mcant_pkg;

   // field widths
   localparam int MODE_W     = 2;
   localparam int COLOR_W    = 8;
   localparam int POS_W      = 8;
   localparam int HEAD_W     = 2;
   localparam int TURN_W     = 2;
   localparam int STATUS_W   = 2;
   localparam int CFG_SIDE_W = 9;
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;
   localparam int REG_IDX_W  = 3;

   typedef logic [MODE_W-1:0]    mode_type;
   typedef logic [COLOR_W-1:0]   color_type;
   typedef logic [POS_W-1:0]     pos_type;
   typedef logic [HEAD_W-1:0]    heading_type;
   typedef logic [STATUS_W-1:0]  status_type;
   typedef logic [REG_IDX_W-1:0] reg_idx_type;

   // request modes
   localparam mode_type MODE_STEP    = 2'd0;
   localparam mode_type MODE_RULE    = 2'd1;
   localparam mode_type MODE_RESTART = 2'd2;

   // result status
   localparam status_type STATUS_DONE    = 2'd0;
   localparam status_type STATUS_MOVED   = 2'd1;
   localparam status_type STATUS_BLOCKED = 2'd2;
   localparam status_type STATUS_OUTSIDE = 2'd3;

   // headings, clockwise from north
   localparam heading_type HEAD_NORTH = 2'd0;
   localparam heading_type HEAD_EAST  = 2'd1;
   localparam heading_type HEAD_SOUTH = 2'd2;
   localparam heading_type HEAD_WEST  = 2'd3;

   // register indexes (byte address = 4 * index)
   localparam reg_idx_type REG_GRID_WIDTH    = 3'd0;
   localparam reg_idx_type REG_GRID_HEIGHT   = 3'd1;
   localparam reg_idx_type REG_INITIAL_COLOR = 3'd2;
   localparam reg_idx_type REG_START_COL     = 3'd3;
   localparam reg_idx_type REG_START_ROW     = 3'd4;
   localparam reg_idx_type REG_START_HEADING = 3'd5;

   localparam logic [CFG_SIDE_W-1:0] SIDE_RESET = 9'd256;

endpackage

// ----- design/mcant_ram.sv -----
// Generic synchronous RAM: one write port, one read port, registered read data.
// Depth is 2**ADDR_W entries of WIDTH bits. No dependencies.
module mcant_ram #(
   parameter int WIDTH  = 8,
   parameter int ADDR_W = 8
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [2**ADDR_W];

   // write, then register the read word
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// ----- design/multicolor_ant_grid_step.sv -----
// Multi-color ant grid stepper: a step runs cell read, rule read and write back in turn,
// set by the two registered memory reads in series; the result strobes in the next cycle.
// Rule write, unused mode and a step with the ant off the grid answer in the cycle after start.
// Restart fills the cell memory, one cell a cycle (2**(2*clog2(MAX_SIDE)) cells, 65536
// by default), result on completion. Reset runs the same fill with color 0 and keeps busy
// high until done; rule entries read as zero until written. Results cannot be stalled.
module multicolor_ant_grid_step #(
   parameter int MAX_SIDE   = 256,
   parameter int NUM_COLORS = 256
) (
   input  logic                          clock,
   input  logic                          reset,
   // request channel
   input  logic                          start,
   output logic                          busy,
   input  mcant_pkg::mode_type           req_mode,
   input  mcant_pkg::color_type          req_rule_index,
   input  mcant_pkg::color_type          req_rule_new_color,
   input  logic signed [1:0]             req_rule_turn,
   // result channel
   output logic                          rsp_valid,
   output mcant_pkg::status_type         rsp_status,
   output mcant_pkg::pos_type            rsp_ant_col,
   output mcant_pkg::pos_type            rsp_ant_row,
   output mcant_pkg::heading_type        rsp_heading,
   output mcant_pkg::color_type          rsp_painted_color,
   // register port
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [4:0]                    paddr,
   input  logic [31:0]                   pwdata,
   output logic [31:0]                   prdata,
   output logic                          pready
);
   import mcant_pkg::*;

   localparam int SIDE_W = $clog2(MAX_SIDE + 1);
   localparam int ADDR_W = 2 * $clog2(MAX_SIDE);
   localparam int RULE_W = $clog2(NUM_COLORS);
   localparam int RULE_D = TURN_W + COLOR_W;

   localparam logic [1:0] ST_SWEEP = 2'd0;
   localparam logic [1:0] ST_IDLE  = 2'd1;
   localparam logic [1:0] ST_RULE  = 2'd2;
   localparam logic [1:0] ST_WB    = 2'd3;

   // clamp a configured side to 1..MAX_SIDE
   function automatic logic [SIDE_W-1:0] clamp_side(input logic [CFG_SIDE_W-1:0] v);
      logic [31:0] wide;
      wide = 32'(v);
      if (wide == 32'd0) begin
         wide = 32'd1;
      end else if (wide > 32'(MAX_SIDE)) begin
         wide = 32'(MAX_SIDE);
      end
      return SIDE_W'(wide);
   endfunction

   // configuration registers
   logic [CFG_SIDE_W-1:0] cfg_width_ff;
   logic [CFG_SIDE_W-1:0] cfg_height_ff;
   color_type             cfg_init_color_ff;
   pos_type               cfg_start_col_ff;
   pos_type               cfg_start_row_ff;
   heading_type           cfg_start_head_ff;

   // control and ant state
   logic [1:0]            state_ff, state_in;
   logic [ADDR_W-1:0]     sweep_addr_ff, sweep_addr_in;
   color_type             fill_color_ff, fill_color_in;
   logic                  report_ff, report_in;
   logic [ADDR_W-1:0]     cell_addr_ff, cell_addr_in;
   pos_type               ant_col_ff, ant_col_in;
   pos_type               ant_row_ff, ant_row_in;
   heading_type           heading_ff, heading_in;
   logic                  rule_ok_ff, rule_ok_in;
   logic [NUM_COLORS-1:0] rule_valid_ff, rule_valid_in;

   // result registers
   logic                  rsp_valid_ff, rsp_valid_in;
   status_type            rsp_status_ff, rsp_status_in;
   color_type             rsp_paint_ff, rsp_paint_in;

   // memory ports
   logic                  cell_wr_en;
   logic [ADDR_W-1:0]     cell_wr_addr;
   color_type             cell_wr_data;
   logic [ADDR_W-1:0]     cell_rd_addr;
   color_type             cell_rd_data;
   logic                  rule_wr_en;
   logic [RULE_W-1:0]     rule_wr_addr;
   logic [RULE_D-1:0]     rule_wr_data;
   logic [RULE_W-1:0]     rule_rd_addr;
   logic [RULE_D-1:0]     rule_rd_data;

   // datapath
   logic [SIDE_W-1:0]     w_side;
   logic [SIDE_W-1:0]     h_side;
   logic                  accept;
   logic                  cfg_write;
   reg_idx_type           cfg_idx;
   logic                  ant_inside;
   logic                  start_inside;
   logic [TURN_W-1:0]     turn_bits;
   color_type             paint;
   heading_type           head_new;
   logic [POS_W:0]        col_inc;
   logic [POS_W:0]        row_inc;
   logic                  move_ok;
   pos_type               move_col;
   pos_type               move_row;

   assign w_side    = clamp_side(cfg_width_ff);
   assign h_side    = clamp_side(cfg_height_ff);
   assign accept    = start && !busy;
   assign busy      = (state_ff != ST_IDLE);
   assign cfg_write = psel && penable && pwrite && pready;
   assign cfg_idx   = paddr[4:2];
   assign pready    = 1'b1;

   // register write
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_width_ff      <= SIDE_RESET;
         cfg_height_ff     <= SIDE_RESET;
         cfg_init_color_ff <= '0;
         cfg_start_col_ff  <= '0;
         cfg_start_row_ff  <= '0;
         cfg_start_head_ff <= HEAD_NORTH;
      end else if (cfg_write) begin
         case (cfg_idx)
            REG_GRID_WIDTH:    cfg_width_ff      <= pwdata[CFG_SIDE_W-1:0];
            REG_GRID_HEIGHT:   cfg_height_ff     <= pwdata[CFG_SIDE_W-1:0];
            REG_INITIAL_COLOR: cfg_init_color_ff <= pwdata[COLOR_W-1:0];
            REG_START_COL:     cfg_start_col_ff  <= pwdata[POS_W-1:0];
            REG_START_ROW:     cfg_start_row_ff  <= pwdata[POS_W-1:0];
            REG_START_HEADING: cfg_start_head_ff <= pwdata[HEAD_W-1:0];
            default: ;
         endcase
      end
   end

   // register read
   always_comb begin
      case (cfg_idx)
         REG_GRID_WIDTH:    prdata = 32'(cfg_width_ff);
         REG_GRID_HEIGHT:   prdata = 32'(cfg_height_ff);
         REG_INITIAL_COLOR: prdata = 32'(cfg_init_color_ff);
         REG_START_COL:     prdata = 32'(cfg_start_col_ff);
         REG_START_ROW:     prdata = 32'(cfg_start_row_ff);
         REG_START_HEADING: prdata = 32'(cfg_start_head_ff);
         default:           prdata = '0;
      endcase
   end

   // grid bound checks and cell address of the ant
   assign ant_inside   = (32'(ant_col_ff) < 32'(w_side)) && (32'(ant_row_ff) < 32'(h_side));
   assign start_inside = (32'(cfg_start_col_ff) < 32'(w_side)) &&
                         (32'(cfg_start_row_ff) < 32'(h_side));
   assign cell_rd_addr = ADDR_W'(32'(ant_row_ff) * 32'(w_side) + 32'(ant_col_ff));

   // rule lookup result, zero for entries never written
   assign turn_bits = rule_ok_ff ? rule_rd_data[RULE_D-1:COLOR_W] : '0;
   assign paint     = rule_ok_ff ? rule_rd_data[COLOR_W-1:0] : '0;
   assign head_new  = heading_ff + turn_bits;
   assign col_inc   = {1'b0, ant_col_ff} + 9'd1;
   assign row_inc   = {1'b0, ant_row_ff} + 9'd1;

   // one cell forward, blocked at the grid edge
   always_comb begin
      move_col = ant_col_ff;
      move_row = ant_row_ff;
      move_ok  = 1'b0;
      case (head_new)
         HEAD_NORTH: begin
            move_ok  = (ant_row_ff != '0);
            move_row = ant_row_ff - 8'd1;
         end
         HEAD_EAST: begin
            move_ok  = (32'(col_inc) < 32'(w_side));
            move_col = col_inc[POS_W-1:0];
         end
         HEAD_SOUTH: begin
            move_ok  = (32'(row_inc) < 32'(h_side));
            move_row = row_inc[POS_W-1:0];
         end
         HEAD_WEST: begin
            move_ok  = (ant_col_ff != '0);
            move_col = ant_col_ff - 8'd1;
         end
         default: ;
      endcase
   end

   // rule table: written straight from the request
   assign rule_wr_en   = accept && (req_mode == MODE_RULE) &&
                         (32'(req_rule_index) < 32'(NUM_COLORS));
   assign rule_wr_addr = RULE_W'(req_rule_index);
   assign rule_wr_data = {req_rule_turn, req_rule_new_color};
   assign rule_rd_addr = RULE_W'(cell_rd_data);

   // cell memory write: fill sweep or step write back
   always_comb begin
      cell_wr_en   = 1'b0;
      cell_wr_addr = cell_addr_ff;
      cell_wr_data = paint;
      if (state_ff == ST_SWEEP) begin
         cell_wr_en   = 1'b1;
         cell_wr_addr = sweep_addr_ff;
         cell_wr_data = fill_color_ff;
      end else if (state_ff == ST_WB) begin
         cell_wr_en = 1'b1;
      end
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      sweep_addr_in = sweep_addr_ff;
      fill_color_in = fill_color_ff;
      report_in     = report_ff;
      cell_addr_in  = cell_addr_ff;
      ant_col_in    = ant_col_ff;
      ant_row_in    = ant_row_ff;
      heading_in    = heading_ff;
      rule_ok_in    = rule_ok_ff;
      rule_valid_in = rule_valid_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_paint_in  = rsp_paint_ff;
      case (state_ff)
         ST_SWEEP: begin
            sweep_addr_in = sweep_addr_ff + 1'b1;
            if (&sweep_addr_ff) begin
               state_in     = ST_IDLE;
               rsp_valid_in = report_ff;
               report_in    = 1'b0;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               rsp_status_in = STATUS_DONE;
               rsp_paint_in  = '0;
               case (req_mode)
                  MODE_STEP: begin
                     if (ant_inside) begin
                        cell_addr_in = cell_rd_addr;
                        state_in     = ST_RULE;
                     end else begin
                        rsp_status_in = STATUS_OUTSIDE;
                        rsp_valid_in  = 1'b1;
                     end
                  end
                  MODE_RULE: begin
                     if (rule_wr_en) begin
                        rule_valid_in[rule_wr_addr] = 1'b1;
                     end
                     rsp_valid_in = 1'b1;
                  end
                  MODE_RESTART: begin
                     fill_color_in = cfg_init_color_ff;
                     ant_col_in    = cfg_start_col_ff;
                     ant_row_in    = cfg_start_row_ff;
                     heading_in    = cfg_start_head_ff;
                     sweep_addr_in = '0;
                     report_in     = 1'b1;
                     state_in      = ST_SWEEP;
                     if (!start_inside) begin
                        rsp_status_in = STATUS_OUTSIDE;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         ST_RULE: begin
            rule_ok_in = (32'(cell_rd_data) < 32'(NUM_COLORS)) &&
                         rule_valid_ff[rule_rd_addr];
            state_in   = ST_WB;
         end
         ST_WB: begin
            heading_in   = head_new;
            rsp_paint_in = paint;
            if (move_ok) begin
               ant_col_in    = move_col;
               ant_row_in    = move_row;
               rsp_status_in = STATUS_MOVED;
            end else begin
               rsp_status_in = STATUS_BLOCKED;
            end
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_SWEEP;
         sweep_addr_ff <= '0;
         fill_color_ff <= '0;
         report_ff     <= 1'b0;
         ant_col_ff    <= '0;
         ant_row_ff    <= '0;
         heading_ff    <= HEAD_NORTH;
         rule_valid_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         sweep_addr_ff <= sweep_addr_in;
         fill_color_ff <= fill_color_in;
         report_ff     <= report_in;
         ant_col_ff    <= ant_col_in;
         ant_row_ff    <= ant_row_in;
         heading_ff    <= heading_in;
         rule_valid_ff <= rule_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cell_addr_ff  <= cell_addr_in;
      rule_ok_ff    <= rule_ok_in;
      rsp_status_ff <= rsp_status_in;
      rsp_paint_ff  <= rsp_paint_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_ant_col       = ant_col_ff;
   assign rsp_ant_row       = ant_row_ff;
   assign rsp_heading       = heading_ff;
   assign rsp_painted_color = rsp_paint_ff;

   mcant_ram #(
      .WIDTH  (COLOR_W),
      .ADDR_W (ADDR_W)
   ) u_cell_ram (
      .clock   (clock),
      .wr_en   (cell_wr_en),
      .wr_addr (cell_wr_addr),
      .wr_data (cell_wr_data),
      .rd_addr (cell_rd_addr),
      .rd_data (cell_rd_data)
   );

   mcant_ram #(
      .WIDTH  (RULE_D),
      .ADDR_W (RULE_W)
   ) u_rule_ram (
      .clock   (clock),
      .wr_en   (rule_wr_en),
      .wr_addr (rule_wr_addr),
      .wr_data (rule_wr_data),
      .rd_addr (rule_rd_addr),
      .rd_data (rule_rd_data)
   );

   // a step on the grid answers once it has passed the rule read and write back states
   a_step_latency: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_mode == MODE_STEP) && ant_inside) |-> ##3 rsp_valid)
      else $error("step result not on time");

   // a moved ant lands inside the grid
   a_moved_inside: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == STATUS_MOVED)) |->
         ((32'(rsp_ant_col) < 32'(w_side)) && (32'(rsp_ant_row) < 32'(h_side))))
      else $error("moved ant outside grid");

   // only a step that ran its rule paints
   a_paint_only_step: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != STATUS_MOVED) && (rsp_status != STATUS_BLOCKED)) |->
         (rsp_painted_color == '0))
      else $error("paint on a result without a step");

   // no result while the fill sweep is still running
   a_quiet_sweep: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_SWEEP) && !(&sweep_addr_ff)) |=> !rsp_valid)
      else $error("result during fill sweep");

endmodule

// ----- sim/testbench.sv -----
// Self-checking testbench for the multi-color ant grid stepper: random and directed requests,
// with a behavioral ant model that predicts every result. Depends on mcant_pkg and
// multicolor_ant_grid_step from the design folder.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import mcant_pkg::*;

   localparam mode_type MODE_UNUSED = 2'd3;
   localparam int GRID_CELLS = 65536;
   localparam int PHASE_COUNT = 5;
   localparam int PHASE_ITEMS = 290;

   typedef struct {
      status_type  status;
      pos_type     col;
      pos_type     row;
      heading_type heading;
      color_type   painted;
   } ant_result_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic              busy;
   mode_type          req_mode = MODE_STEP;
   color_type         req_rule_index = '0;
   color_type         req_rule_new_color = '0;
   logic signed [1:0] req_rule_turn = '0;
   logic              rsp_valid;
   status_type        rsp_status;
   pos_type           rsp_ant_col;
   pos_type           rsp_ant_row;
   heading_type       rsp_heading;
   color_type         rsp_painted_color;
   logic              psel = 1'b0;
   logic              penable = 1'b0;
   logic              pwrite = 1'b0;
   logic [4:0]        paddr = '0;
   logic [31:0]       pwdata = '0;
   logic [31:0]       prdata;
   logic              pready;

   // ant model state and register shadows
   color_type         cell_mem [GRID_CELLS];
   color_type         rule_color [256];
   logic [1:0]        rule_turn [256];
   pos_type           ant_col_m;
   pos_type           ant_row_m;
   heading_type       ant_head_m;
   logic [8:0]        cfg_width;
   logic [8:0]        cfg_height;
   color_type         cfg_init_color;
   pos_type           cfg_start_col;
   pos_type           cfg_start_row;
   heading_type       cfg_start_head;

   ant_result_type    expected_results [$];
   int                failures = 0;
   bit                no_gaps = 1'b0;

   multicolor_ant_grid_step dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_mode           (req_mode),
      .req_rule_index     (req_rule_index),
      .req_rule_new_color (req_rule_new_color),
      .req_rule_turn      (req_rule_turn),
      .rsp_valid          (rsp_valid),
      .rsp_status         (rsp_status),
      .rsp_ant_col        (rsp_ant_col),
      .rsp_ant_row        (rsp_ant_row),
      .rsp_heading        (rsp_heading),
      .rsp_painted_color  (rsp_painted_color),
      .psel               (psel),
      .penable            (penable),
      .pwrite             (pwrite),
      .paddr              (paddr),
      .pwdata             (pwdata),
      .prdata             (prdata),
      .pready             (pready)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // a size of 0 acts as 1, anything past 256 acts as 256
   function automatic int unsigned grid_side(logic [8:0] v);
      if (v == 0) return 1;
      if (v > 256) return 256;
      return 32'(v);
   endfunction

   function automatic void place_ant_model();
      foreach (cell_mem[i]) cell_mem[i] = cfg_init_color;
      ant_col_m  = cfg_start_col;
      ant_row_m  = cfg_start_row;
      ant_head_m = cfg_start_head;
   endfunction

   // apply one request to the ant model and return the result it must produce
   function automatic ant_result_type predict_ant(mode_type mode, color_type idx,
                                                  color_type new_color, logic [1:0] turn);
      ant_result_type r;
      int unsigned    w;
      int unsigned    h;
      int unsigned    cell_idx;
      int unsigned    ncol;
      int unsigned    nrow;
      color_type      here;
      bit             ok;
      w = grid_side(cfg_width);
      h = grid_side(cfg_height);
      r.status  = STATUS_DONE;
      r.painted = '0;
      case (mode)
         MODE_RULE: begin
            rule_color[idx] = new_color;
            rule_turn[idx]  = turn;
         end
         MODE_RESTART: begin
            place_ant_model();
            if (ant_col_m >= w || ant_row_m >= h) r.status = STATUS_OUTSIDE;
         end
         MODE_STEP: begin
            if (ant_col_m >= w || ant_row_m >= h) begin
               r.status = STATUS_OUTSIDE;
            end else begin
               cell_idx = ant_row_m * w + ant_col_m;
               here = cell_mem[cell_idx];
               // turn first, then paint, then try to move
               ant_head_m = ant_head_m + rule_turn[here];
               r.painted = rule_color[here];
               cell_mem[cell_idx] = r.painted;
               ncol = 32'(ant_col_m);
               nrow = 32'(ant_row_m);
               ok = 1'b1;
               case (ant_head_m)
                  HEAD_NORTH: if (nrow == 0) ok = 1'b0; else nrow--;
                  HEAD_EAST:  ncol++;
                  HEAD_SOUTH: nrow++;
                  default:    if (ncol == 0) ok = 1'b0; else ncol--;
               endcase
               if (ncol >= w || nrow >= h) ok = 1'b0;
               if (ok) begin
                  ant_col_m = pos_type'(ncol);
                  ant_row_m = pos_type'(nrow);
                  r.status = STATUS_MOVED;
               end else begin
                  r.status = STATUS_BLOCKED;
               end
            end
         end
         default: ;
      endcase
      r.col     = ant_col_m;
      r.row     = ant_row_m;
      r.heading = ant_head_m;
      return r;
   endfunction

   // compare each strobed result with the oldest prediction
   always @(posedge clock) begin
      ant_result_type want;
      if (!reset && rsp_valid === 1'b1) begin
         if (expected_results.size() == 0) begin
            $error("result with no request outstanding");
            failures++;
         end else begin
            want = expected_results.pop_front();
            if (rsp_status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_status);
               failures++;
            end
            if (rsp_ant_col !== want.col) begin
               $error("ant_col: expected %0d, got %0d", want.col, rsp_ant_col);
               failures++;
            end
            if (rsp_ant_row !== want.row) begin
               $error("ant_row: expected %0d, got %0d", want.row, rsp_ant_row);
               failures++;
            end
            if (rsp_heading !== want.heading) begin
               $error("heading: expected %0d, got %0d", want.heading, rsp_heading);
               failures++;
            end
            if (rsp_painted_color !== want.painted) begin
               $error("painted_color: expected %0d, got %0d", want.painted, rsp_painted_color);
               failures++;
            end
         end
      end
   end

   // all driving tasks start and end at a falling edge
   task automatic csr_write(reg_idx_type idx, logic [31:0] value);
      psel    = 1'b1;
      pwrite  = 1'b1;
      penable = 1'b0;
      paddr   = {idx, 2'b00};
      pwdata  = value;
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      case (idx)
         REG_GRID_WIDTH:    cfg_width      = value[8:0];
         REG_GRID_HEIGHT:   cfg_height     = value[8:0];
         REG_INITIAL_COLOR: cfg_init_color = value[7:0];
         REG_START_COL:     cfg_start_col  = value[7:0];
         REG_START_ROW:     cfg_start_row  = value[7:0];
         REG_START_HEADING: cfg_start_head = value[1:0];
         default: ;
      endcase
      @(negedge clock);
      psel    = 1'b0;
      penable = 1'b0;
      pwrite  = 1'b0;
   endtask

   task automatic send_request(mode_type mode, color_type idx, color_type new_color,
                               logic [1:0] turn);
      ant_result_type predicted;
      // insert a random gap unless in a no-gap stretch
      if (!no_gaps && $urandom_range(0, 99) < 23) begin
         start = 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      req_mode           = mode;
      req_rule_index     = idx;
      req_rule_new_color = new_color;
      req_rule_turn      = turn;
      start              = 1'b1;
      do @(posedge clock); while (busy !== 1'b0);
      predicted = predict_ant(mode, idx, new_color, turn);
      expected_results.insert(expected_results.size(), predicted);
      @(negedge clock);
      start = 1'b0;
   endtask

   task automatic step_ant(int count);
      repeat (count) send_request(MODE_STEP, color_type'($urandom), color_type'($urandom),
                                  2'($urandom));
   endtask

   task automatic write_rule(color_type idx, color_type new_color, logic [1:0] turn);
      send_request(MODE_RULE, idx, new_color, turn);
   endtask

   task automatic restart_grid();
      send_request(MODE_RESTART, color_type'($urandom), color_type'($urandom), 2'($urandom));
   endtask

   // hold until every predicted result has come and the block is idle
   task automatic wait_for_results();
      while (expected_results.size() != 0) @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic test_reset_state();
      // default rules are straight with color 0; heading north from row 0 is blocked
      step_ant(2);
      send_request(MODE_UNUSED, 8'hFF, 8'hFF, 2'b11);
      wait_for_results();
   endtask

   task automatic test_rule_walk();
      csr_write(REG_GRID_WIDTH, 32'd4);
      csr_write(REG_GRID_HEIGHT, 32'd3);
      csr_write(REG_INITIAL_COLOR, 32'hFF);
      csr_write(REG_START_COL, 32'd3);
      csr_write(REG_START_ROW, 32'd2);
      csr_write(REG_START_HEADING, 32'(HEAD_NORTH));
      // straight on the fill color, then ccw, U-turn and cw on painted colors
      write_rule(8'hFF, 8'h80, 2'b00);
      write_rule(8'h80, 8'h01, 2'b11);
      write_rule(8'h01, 8'h7F, 2'b10);
      write_rule(8'h7F, 8'h00, 2'b01);
      write_rule(8'h00, 8'hFF, 2'b01);
      restart_grid();
      step_ant(16);
      wait_for_results();
   endtask

   task automatic test_off_grid_start();
      csr_write(REG_GRID_WIDTH, 32'd8);
      csr_write(REG_GRID_HEIGHT, 32'd8);
      csr_write(REG_START_COL, 32'd200);
      csr_write(REG_START_ROW, 32'd255);
      csr_write(REG_START_HEADING, 32'(HEAD_WEST));
      restart_grid();
      step_ant(1);
      wait_for_results();
      // widen past the top: the ant is back on the grid without a restart
      csr_write(REG_GRID_WIDTH, 32'd511);
      csr_write(REG_GRID_HEIGHT, 32'd256);
      step_ant(3);
      wait_for_results();
      // shrink to zero size, which acts as a single cell
      csr_write(REG_GRID_WIDTH, 32'd0);
      csr_write(REG_GRID_HEIGHT, 32'd0);
      step_ant(1);
      wait_for_results();
      csr_write(REG_START_COL, 32'd0);
      csr_write(REG_START_ROW, 32'd0);
      restart_grid();
      step_ant(3);
      wait_for_results();
   endtask

   function automatic logic [8:0] pick_side();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 80) return 9'($urandom_range(2, 12));
      if (r < 90) return 9'($urandom_range(0, 1));
      return 9'($urandom_range(200, 511));
   endfunction

   function automatic pos_type pick_start(logic [8:0] side);
      if ($urandom_range(0, 99) < 85) return pos_type'($urandom_range(0, grid_side(side) - 1));
      return pos_type'($urandom_range(0, 255));
   endfunction

   task automatic test_random_phases();
      int unsigned r;
      color_type   idx;
      color_type   new_color;
      for (int ph = 0; ph < PHASE_COUNT; ph++) begin
         no_gaps = (ph == 2);
         csr_write(REG_GRID_WIDTH, 32'(pick_side()));
         csr_write(REG_GRID_HEIGHT, 32'(pick_side()));
         csr_write(REG_INITIAL_COLOR, $urandom_range(0, 5));
         csr_write(REG_START_COL, 32'(pick_start(cfg_width)));
         csr_write(REG_START_ROW, 32'(pick_start(cfg_height)));
         csr_write(REG_START_HEADING, $urandom_range(0, 3));
         // give the small palette turning rules so the walk revisits cells
         for (int c = 0; c < 6; c++) begin
            write_rule(color_type'(c), color_type'($urandom_range(0, 5)),
                       2'($urandom_range(1, 3)));
         end
         restart_grid();
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            // resize mid-phase without restarting
            if (i == PHASE_ITEMS / 2) begin
               wait_for_results();
               csr_write(REG_GRID_WIDTH, 32'(pick_side()));
               csr_write(REG_GRID_HEIGHT, 32'(pick_side()));
            end else if ($urandom_range(0, 99) == 0) begin
               wait_for_results();
            end
            r = $urandom_range(0, 99);
            if (r < 74) begin
               step_ant(1);
            end else if (r < 95) begin
               if ($urandom_range(0, 3) == 0) begin
                  idx       = color_type'($urandom_range(0, 255));
                  new_color = color_type'($urandom_range(0, 255));
               end else begin
                  idx       = color_type'($urandom_range(0, 5));
                  new_color = color_type'($urandom_range(0, 5));
               end
               write_rule(idx, new_color, 2'($urandom_range(0, 3)));
            end else begin
               send_request(MODE_UNUSED, color_type'($urandom), color_type'($urandom),
                            2'($urandom));
            end
         end
         wait_for_results();
      end
      no_gaps = 1'b0;
   endtask

   // bound the run in case the block hangs
   initial begin
      #50_000_000;
      $display("multicolor_ant_grid_step regression: fail");
      $finish;
   end

   initial begin
      // reset values of the model
      cfg_width      = SIDE_RESET;
      cfg_height     = SIDE_RESET;
      cfg_init_color = '0;
      cfg_start_col  = '0;
      cfg_start_row  = '0;
      cfg_start_head = HEAD_NORTH;
      foreach (rule_color[i]) begin
         rule_color[i] = '0;
         rule_turn[i]  = '0;
      end
      place_ant_model();

      // hold reset, then wait out the clearing pass
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      while (busy !== 1'b0) @(posedge clock);
      @(negedge clock);

      test_reset_state();
      test_rule_walk();
      test_off_grid_start();
      test_random_phases();

      wait_for_results();
      repeat (20) @(posedge clock);
      if (failures == 0 && expected_results.size() == 0) begin
         $display("multicolor_ant_grid_step regression: pass");
      end else begin
         $display("multicolor_ant_grid_step regression: fail");
      end
      $finish;
   end

endmodule

// ----- multicolor_ant_grid_step.f -----
design/mcant_pkg.sv
design/mcant_ram.sv
design/multicolor_ant_grid_step.sv
sim/testbench.sv
